// ===== design/spns_pkg.sv =====
package spns_pkg;

  localparam int MUL_W  = 66;
  localparam int PROD_W = 2 * MUL_W;
  localparam int NUM_W  = 131;
  localparam int DEN_W  = 128;
  localparam int DIV_W  = 160;
  localparam int QUO_W  = 32;
  localparam int RAD_W  = 66;
  localparam int ROOT_W = 33;

  typedef enum logic [0:0] {
    CFG_LENGTH_TOL = 1'b0,
    CFG_DET_TOL    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] surf_x;
    logic signed [31:0] surf_y;
    logic signed [31:0] surf_z;
    logic signed [31:0] tan_u_x;
    logic signed [31:0] tan_u_y;
    logic signed [31:0] tan_u_z;
    logic signed [31:0] tan_v_x;
    logic signed [31:0] tan_v_y;
    logic signed [31:0] tan_v_z;
  } in_t;

  typedef struct packed {
    logic        [32:0] distance;
    logic signed [31:0] step_u;
    logic signed [31:0] step_v;
    logic               degenerate;
  } out_t;

endpackage

// ===== design/spns_mul.sv =====
module spns_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic [spns_pkg::MUL_W-1:0]     a,
  input  logic [spns_pkg::MUL_W-1:0]     b,
  output logic [spns_pkg::PROD_W-1:0]    p
);

  localparam int CW = spns_pkg::MUL_W / 3;

  logic [2*CW-1:0] pp  [3][3];
  logic [4*CW-1:0] row [3];

  // three stages: 22x22 partial products, row sums, final sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp[i][j] <= a[i*CW +: CW] * b[j*CW +: CW];
        end
      end
      for (int i = 0; i < 3; i++) begin
        row[i] <= {{(2*CW){1'b0}}, pp[i][0]}
                + {{CW{1'b0}}, pp[i][1], {CW{1'b0}}}
                + {pp[i][2], {(2*CW){1'b0}}};
      end
      p <= {{(2*CW){1'b0}}, row[0]}
         + {{CW{1'b0}}, row[1], {CW{1'b0}}}
         + {row[2], {(2*CW){1'b0}}};
    end
  end

endmodule

// ===== design/spns_div.sv =====
module spns_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic [spns_pkg::NUM_W-1:0]          num,
  input  logic                                neg,
  input  logic [spns_pkg::DEN_W-1:0]          den,
  output logic signed [spns_pkg::QUO_W-1:0]   quo
);

  localparam int W      = spns_pkg::DIV_W;
  localparam int QB     = spns_pkg::QUO_W - 1;
  localparam int STAGES = QB + 1;

  logic [W-1:0]                n_q    [STAGES];
  logic [spns_pkg::DEN_W-1:0]  den_q  [STAGES];
  logic                        neg_q  [STAGES];
  logic                        sat_q  [STAGES];
  logic                        zero_q [STAGES];
  logic [QB-1:0]               q_q    [STAGES];

  // stage 0 checks saturation, then one quotient bit per stage, MSB first
  always_ff @(posedge clk) begin
    if (en) begin
      n_q[0]    <= {{(W-spns_pkg::NUM_W-16){1'b0}}, num, 16'b0};
      den_q[0]  <= den;
      neg_q[0]  <= neg;
      sat_q[0]  <= {{(W-spns_pkg::NUM_W-16){1'b0}}, num, 16'b0}
                   >= {{(W-spns_pkg::DEN_W-QB){1'b0}}, den, {QB{1'b0}}};
      zero_q[0] <= (den == '0);
      q_q[0]    <= '0;
    end
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    logic [W-1:0]  dsh;
    logic          ge;
    logic [QB-1:0] q_next;

    always_comb begin
      dsh    = {{(W-spns_pkg::DEN_W){1'b0}}, den_q[k-1]} << (QB - k);
      ge     = n_q[k-1] >= dsh;
      q_next = q_q[k-1];
      q_next[QB-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k]    <= ge ? n_q[k-1] - dsh : n_q[k-1];
        den_q[k]  <= den_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        sat_q[k]  <= sat_q[k-1];
        zero_q[k] <= zero_q[k-1];
        q_q[k]    <= q_next;
      end
    end
  end

  always_comb begin
    if (zero_q[STAGES-1]) begin
      quo = '0;
    end else if (sat_q[STAGES-1]) begin
      quo = neg_q[STAGES-1] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    end else if (neg_q[STAGES-1]) begin
      quo = -{1'b0, q_q[STAGES-1]};
    end else begin
      quo = {1'b0, q_q[STAGES-1]};
    end
  end

endmodule

// ===== design/spns_sqrt.sv =====
module spns_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [spns_pkg::RAD_W-1:0]    rad,
  output logic [spns_pkg::ROOT_W-1:0]   root
);

  localparam int RW    = spns_pkg::ROOT_W;
  localparam int SW    = spns_pkg::RAD_W;
  localparam int REM_W = RW + 3;

  logic [REM_W-1:0] rem_q  [RW];
  logic [RW-1:0]    root_q [RW];
  logic [SW-1:0]    src_q  [RW];

  // digit-by-digit, two radicand bits per stage
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [RW-1:0]    root_in;
    logic [SW-1:0]    src_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign src_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign src_in  = src_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], src_in[SW-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[RW-2:0], 1'b0};
        end
        src_q[k] <= {src_in[SW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

// ===== design/surface_point_newton_step.sv =====
// Throughput: one transaction per cycle; the whole pipeline stalls only
// while the output register holds a result that is not taken.
// Depth is set by the 32-stage bit-serial quotient pipeline and the
// 33-stage square root. Reset clears all valid bits and sets both
// tolerance registers to 1.
module surface_point_newton_step #(
  parameter int DIM = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spns_pkg::in_t        in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spns_pkg::out_t       out_data,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int DLY = spns_pkg::QUO_W;

  typedef struct packed {
    logic        short_u;
    logic        short_v;
    logic        long_v;
    logic        s2;
    logic        nz2;
    logic        s4;
    logic        s5;
    logic [63:0] t1;
    logic [63:0] t3;
    logic [63:0] t2m;
    logic [64:0] t4m;
    logic [64:0] t5m;
    logic [65:0] dd;
  } side_t;

  function automatic logic signed [spns_pkg::PROD_W:0] apply_sign(
    input logic [spns_pkg::PROD_W-1:0] m,
    input logic                        s
  );
    logic signed [spns_pkg::PROD_W:0] x;
    x = {1'b0, m};
    return s ? -x : x;
  endfunction

  logic        en;
  logic [31:0] length_tolerance;
  logic [31:0] det_tolerance;
  logic [63:0] tol2;

  logic signed [31:0] tgt [3];
  logic signed [31:0] srf [3];
  logic signed [31:0] tu  [3];
  logic signed [31:0] tv  [3];

  logic               v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic signed [32:0] p1  [3];
  logic signed [31:0] su1 [3];
  logic signed [31:0] sv1 [3];

  logic signed [63:0] pr_uu [3];
  logic signed [63:0] pr_uv [3];
  logic signed [63:0] pr_vv [3];
  logic signed [64:0] pr_pu [3];
  logic signed [64:0] pr_pv [3];
  logic signed [65:0] pr_pp [3];

  logic [63:0]        t1_3, t3_3;
  logic signed [64:0] t2_3;
  logic signed [65:0] t4_3, t5_3;
  logic [65:0]        dd_3;

  side_t side4, side5, side6, side7, side8;
  logic [spns_pkg::PROD_W-1:0] m1, m2, m3, m4, m5, m6;

  logic [spns_pkg::DEN_W-1:0]      det8;
  logic signed [spns_pkg::PROD_W:0] n1_8, n2_8;

  logic                          parallel, dg0, singular;
  logic [spns_pkg::NUM_W-1:0]    n1m, n2m;
  logic [spns_pkg::NUM_W-1:0]    num_u9, num_v9;
  logic [spns_pkg::DEN_W-1:0]    den_u9, den_v9;
  logic                          neg_u9, neg_v9, degen9;

  logic                            degen_d [DLY];
  logic                            valid_d [DLY];
  logic signed [spns_pkg::QUO_W-1:0] du, dv;
  logic [spns_pkg::ROOT_W-1:0]       root;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_tolerance <= 32'd1;
      det_tolerance    <= 32'd1;
    end else if (cfg_we) begin
      case (spns_pkg::cfg_idx_t'(cfg_index))
        spns_pkg::CFG_LENGTH_TOL: length_tolerance <= cfg_data;
        spns_pkg::CFG_DET_TOL:    det_tolerance    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tol2 <= length_tolerance * length_tolerance;
  end

  always_comb begin
    tgt[0] = in_data.target_x; tgt[1] = in_data.target_y; tgt[2] = in_data.target_z;
    srf[0] = in_data.surf_x;   srf[1] = in_data.surf_y;   srf[2] = in_data.surf_z;
    tu[0]  = in_data.tan_u_x;  tu[1]  = in_data.tan_u_y;  tu[2]  = in_data.tan_u_z;
    tv[0]  = in_data.tan_v_x;  tv[1]  = in_data.tan_v_y;  tv[2]  = in_data.tan_v_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8;
    end
  end

  // difference vector, then component products, then dot sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p1[k]  <= 33'(tgt[k]) - 33'(srf[k]);
        su1[k] <= tu[k];
        sv1[k] <= tv[k];
      end
      for (int k = 0; k < 3; k++) begin
        if (k < DIM) begin
          pr_uu[k] <= su1[k] * su1[k];
          pr_uv[k] <= su1[k] * sv1[k];
          pr_vv[k] <= sv1[k] * sv1[k];
          pr_pu[k] <= p1[k] * su1[k];
          pr_pv[k] <= p1[k] * sv1[k];
          pr_pp[k] <= p1[k] * p1[k];
        end else begin
          pr_uu[k] <= '0;
          pr_uv[k] <= '0;
          pr_vv[k] <= '0;
          pr_pu[k] <= '0;
          pr_pv[k] <= '0;
          pr_pp[k] <= '0;
        end
      end
      t1_3 <= pr_uu[0] + pr_uu[1] + pr_uu[2];
      t3_3 <= pr_vv[0] + pr_vv[1] + pr_vv[2];
      t2_3 <= 65'(pr_uv[0]) + 65'(pr_uv[1]) + 65'(pr_uv[2]);
      t4_3 <= 66'(pr_pu[0]) + 66'(pr_pu[1]) + 66'(pr_pu[2]);
      t5_3 <= 66'(pr_pv[0]) + 66'(pr_pv[1]) + 66'(pr_pv[2]);
      dd_3 <= pr_pp[0] + pr_pp[1] + pr_pp[2];
    end
  end

  // tolerance tests and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      side4.short_u <= t1_3 < tol2;
      side4.short_v <= t3_3 < tol2;
      side4.long_v  <= t3_3 > tol2;
      side4.s2      <= t2_3[64];
      side4.nz2     <= t2_3 != '0;
      side4.s4      <= t4_3[65];
      side4.s5      <= t5_3[65];
      side4.t1      <= t1_3;
      side4.t3      <= t3_3;
      side4.t2m     <= t2_3[64] ? 64'(-t2_3) : t2_3[63:0];
      side4.t4m     <= t4_3[65] ? 65'(-t4_3) : t4_3[64:0];
      side4.t5m     <= t5_3[65] ? 65'(-t5_3) : t5_3[64:0];
      side4.dd      <= dd_3;
      side5 <= side4;
      side6 <= side5;
      side7 <= side6;
    end
  end

  spns_mul u_m1 (.clk, .en, .a({2'b0, side4.t1}),  .b({2'b0, side4.t3}),  .p(m1));
  spns_mul u_m2 (.clk, .en, .a({2'b0, side4.t2m}), .b({2'b0, side4.t2m}), .p(m2));
  spns_mul u_m3 (.clk, .en, .a({1'b0, side4.t4m}), .b({2'b0, side4.t3}),  .p(m3));
  spns_mul u_m4 (.clk, .en, .a({1'b0, side4.t5m}), .b({2'b0, side4.t2m}), .p(m4));
  spns_mul u_m5 (.clk, .en, .a({2'b0, side4.t1}),  .b({1'b0, side4.t5m}), .p(m5));
  spns_mul u_m6 (.clk, .en, .a({2'b0, side4.t2m}), .b({1'b0, side4.t4m}), .p(m6));

  // Gram determinant and Cramer numerators
  always_ff @(posedge clk) begin
    if (en) begin
      side8 <= side7;
      det8  <= spns_pkg::DEN_W'(m1 - m2);
      n1_8  <= apply_sign(m3, side7.s4) - apply_sign(m4, side7.s5 ^ side7.s2);
      n2_8  <= apply_sign(m5, side7.s5) - apply_sign(m6, side7.s2 ^ side7.s4);
    end
  end

  always_comb begin
    parallel = !side8.s2 && side8.nz2 && (det8 == '0);
    dg0      = side8.short_u || side8.short_v || parallel;
    singular = (det8 == '0) || (det8 < {64'b0, det_tolerance, 32'b0});
    n1m      = n1_8[spns_pkg::PROD_W] ? spns_pkg::NUM_W'(-n1_8)
                                      : spns_pkg::NUM_W'(n1_8);
    n2m      = n2_8[spns_pkg::PROD_W] ? spns_pkg::NUM_W'(-n2_8)
                                      : spns_pkg::NUM_W'(n2_8);
  end

  // short or parallel tangents project onto one tangent; a zero divisor forces a zero step
  always_ff @(posedge clk) begin
    if (en) begin
      degen9 <= dg0 || singular;
      if (dg0) begin
        num_u9 <= spns_pkg::NUM_W'(side8.t4m);
        neg_u9 <= side8.s4;
        den_u9 <= side8.short_u ? '0 : spns_pkg::DEN_W'(side8.t1);
        num_v9 <= spns_pkg::NUM_W'(side8.t5m);
        neg_v9 <= side8.s5;
        den_v9 <= (side8.short_u && side8.long_v) ? spns_pkg::DEN_W'(side8.t3) : '0;
      end else begin
        num_u9 <= n1m;
        neg_u9 <= n1_8[spns_pkg::PROD_W];
        den_u9 <= singular ? '0 : det8;
        num_v9 <= n2m;
        neg_v9 <= n2_8[spns_pkg::PROD_W];
        den_v9 <= singular ? '0 : det8;
      end
    end
  end

  spns_div u_div_u (
    .clk, .en, .num(num_u9), .neg(neg_u9), .den(den_u9), .quo(du)
  );

  spns_div u_div_v (
    .clk, .en, .num(num_v9), .neg(neg_v9), .den(den_v9), .quo(dv)
  );

  spns_sqrt u_sqrt (
    .clk, .en, .rad(side8.dd), .root(root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      degen_d[0] <= degen9;
      for (int k = 1; k < DLY; k++) begin
        degen_d[k] <= degen_d[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DLY; k++) begin
        valid_d[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      valid_d[0] <= v9;
      for (int k = 1; k < DLY; k++) begin
        valid_d[k] <= valid_d[k-1];
      end
      out_valid <= valid_d[DLY-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.distance   <= root;
      out_data.step_u     <= du;
      out_data.step_v     <= dv;
      out_data.degenerate <= degen_d[DLY-1];
    end
  end

endmodule

// ===== verif/spns_checker.sv =====
`timescale 1ns / 1ps
module spns_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  spns_pkg::in_t   in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  spns_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output int              errors,
  output int              pending
);

  typedef logic signed [219:0] wide_t;

  logic [31:0]    len_tol;
  logic [31:0]    det_tol;
  spns_pkg::out_t expected_steps[$];

  function automatic wide_t dot3(wide_t a0, wide_t a1, wide_t a2,
                                 wide_t b0, wide_t b1, wide_t b2);
    return a0 * b0 + a1 * b1 + a2 * b2;
  endfunction

  // Q16.16 quotient, truncated toward zero, saturated
  function automatic logic signed [31:0] fixed_quot(wide_t num, wide_t den);
    wide_t mag;
    wide_t n;
    wide_t q;
    if (den == 0) return 32'sd0;
    mag = (num < 0) ? -num : num;
    n = mag <<< 16;
    if (n >= (den <<< 31)) return (num < 0) ? 32'sh80000000 : 32'sh7fffffff;
    q = n / den;
    return (num < 0) ? -q[31:0] : q[31:0];
  endfunction

  function automatic logic [32:0] isqrt(wide_t s);
    wide_t r;
    wide_t cand;
    r = 0;
    for (int b = 33; b >= 0; b--) begin
      cand = r | (wide_t'(1) <<< b);
      if (cand * cand <= s) r = cand;
    end
    return r[32:0];
  endfunction

  function automatic spns_pkg::out_t step_for(spns_pkg::in_t x);
    wide_t px, py, pz, ux, uy, uz, vx, vy, vz;
    wide_t uu, uv, vv, pu, pv, pp, tol2, det;
    logic  short_u, short_v, long_v, parallel, degen;
    logic signed [31:0] du, dv;
    spns_pkg::out_t r;
    px = wide_t'(x.target_x) - wide_t'(x.surf_x);
    py = wide_t'(x.target_y) - wide_t'(x.surf_y);
    pz = wide_t'(x.target_z) - wide_t'(x.surf_z);
    ux = x.tan_u_x; uy = x.tan_u_y; uz = x.tan_u_z;
    vx = x.tan_v_x; vy = x.tan_v_y; vz = x.tan_v_z;
    uu = dot3(ux, uy, uz, ux, uy, uz);
    uv = dot3(ux, uy, uz, vx, vy, vz);
    vv = dot3(vx, vy, vz, vx, vy, vz);
    pu = dot3(px, py, pz, ux, uy, uz);
    pv = dot3(px, py, pz, vx, vy, vz);
    pp = dot3(px, py, pz, px, py, pz);
    tol2 = wide_t'({1'b0, len_tol}) * wide_t'({1'b0, len_tol});
    short_u = uu < tol2;
    short_v = vv < tol2;
    long_v = vv > tol2;
    det = uu * vv - uv * uv;
    parallel = (uv > 0) && (det == 0);
    degen = short_u || short_v || parallel;
    du = 0;
    dv = 0;
    if (degen) begin
      if (short_u) begin
        if (long_v) dv = fixed_quot(pv, vv);
      end else begin
        du = fixed_quot(pu, uu);
      end
    end else if (det == 0 || det < (wide_t'({1'b0, det_tol}) <<< 32)) begin
      degen = 1'b1;
    end else begin
      du = fixed_quot(pu * vv - pv * uv, det);
      dv = fixed_quot(uu * pv - uv * pu, det);
    end
    r.distance = isqrt(pp);
    r.step_u = du;
    r.step_v = dv;
    r.degenerate = degen;
    return r;
  endfunction

  assign pending = expected_steps.size();

  always @(posedge clk) begin
    spns_pkg::out_t e;
    int nerr;
    nerr = 0;
    if (rst) begin
      len_tol <= 32'd1;
      det_tol <= 32'd1;
      expected_steps.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == spns_pkg::CFG_LENGTH_TOL) len_tol <= cfg_data;
        else det_tol <= cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_steps.size() == 0) begin
          $error("unexpected output transaction");
          nerr = nerr + 1;
        end else begin
          e = expected_steps.pop_front();
          if (out_data.distance !== e.distance) begin
            $error("distance: expected %0d, got %0d", e.distance, out_data.distance);
            nerr = nerr + 1;
          end
          if (out_data.step_u !== e.step_u) begin
            $error("step_u: expected %0d, got %0d", e.step_u, out_data.step_u);
            nerr = nerr + 1;
          end
          if (out_data.step_v !== e.step_v) begin
            $error("step_v: expected %0d, got %0d", e.step_v, out_data.step_v);
            nerr = nerr + 1;
          end
          if (out_data.degenerate !== e.degenerate) begin
            $error("degenerate: expected %0b, got %0b", e.degenerate,
                   out_data.degenerate);
            nerr = nerr + 1;
          end
        end
      end
      errors <= errors + nerr;
      if (in_valid && in_ready) expected_steps.push_back(step_for(in_data));
    end
  end
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int LIMIT = 300000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  spns_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  spns_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [0:0]     cfg_index = spns_pkg::CFG_LENGTH_TOL;
  logic [31:0]    cfg_data = '0;
  int             errors;
  int             pending;
  int             cycles = 0;
  int             max_gap = 4;

  always #2 clk = ~clk;

  surface_point_newton_step dut (.*);

  spns_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall before each result, calm stretches when max_gap is 0
  always begin
    int stall;
    @(posedge clk);
    if (!rst) begin
      stall = $urandom_range(0, max_gap);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic write_reg(spns_pkg::cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send(spns_pkg::in_t x);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(0, 6))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      3: return 32'($signed($urandom_range(0, 32'hffffff)) - 32'sh800000);
      4: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
      5: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
      default: return 32'($signed($urandom_range(0, 8)) - 32'sd4);
    endcase
  endfunction

  function automatic spns_pkg::in_t rand_query();
    spns_pkg::in_t x;
    int  k;
    x.target_x = coord(); x.target_y = coord(); x.target_z = coord();
    x.surf_x = coord(); x.surf_y = coord(); x.surf_z = coord();
    x.tan_u_x = coord(); x.tan_u_y = coord(); x.tan_u_z = coord();
    x.tan_v_x = coord(); x.tan_v_y = coord(); x.tan_v_z = coord();
    case ($urandom_range(0, 5))
      0: begin
        k = $urandom_range(1, 5);
        if ($urandom_range(0, 1)) k = -k;
        x.tan_u_x = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        x.tan_u_y = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        x.tan_u_z = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        x.tan_v_x = x.tan_u_x * k;
        x.tan_v_y = x.tan_u_y * k;
        x.tan_v_z = x.tan_u_z * k;
      end
      1: begin
        x.tan_u_x = $signed($urandom_range(0, 6)) - 3;
        x.tan_u_y = $signed($urandom_range(0, 6)) - 3;
        x.tan_u_z = 0;
      end
      2: begin
        x.tan_v_x = $signed($urandom_range(0, 6)) - 3;
        x.tan_v_y = 0;
        x.tan_v_z = $signed($urandom_range(0, 6)) - 3;
      end
      default: ;
    endcase
    return x;
  endfunction

  function automatic spns_pkg::in_t mk(int tx, int ty, int tz, int ux, int uy, int uz,
                                       int vx, int vy, int vz);
    spns_pkg::in_t x;
    x = '0;
    x.target_x = tx; x.target_y = ty; x.target_z = tz;
    x.tan_u_x = ux; x.tan_u_y = uy; x.tan_u_z = uz;
    x.tan_v_x = vx; x.tan_v_y = vy; x.tan_v_z = vz;
    return x;
  endfunction

  initial begin
    spns_pkg::in_t x;
    logic [31:0] lt [5];
    logic [31:0] dt [5];
    lt = '{32'd1, 32'd0, 32'hffffffff, 32'h00010000, 32'h00000100};
    dt = '{32'd1, 32'd0, 32'hffffffff, 32'h00000001, 32'h00100000};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, extremes, short tangents, parallel, antiparallel, singular
    send('0);
    send(mk(32'h10000, 32'h20000, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
    send(mk(5, 7, 9, 0, 0, 0, 32'h10000, 0, 0));
    send(mk(5, 7, 9, 0, 0, 0, 0, 0, 0));
    send(mk(5, 7, 9, 32'h10000, 0, 0, 0, 0, 0));
    send(mk(5, 7, 9, 3, 4, 5, 6, 8, 10));
    send(mk(5, 7, 9, 3, 4, 5, -3, -4, -5));
    send(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0, 0, 0, 1, 0));
    send(mk(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 0, 1, 2, 0));
    x = '{default: 32'h7fffffff};
    x.surf_x = 32'h80000000; x.surf_y = 32'h80000000; x.surf_z = 32'h80000000;
    send(x);
    x = '{default: 32'h80000000};
    send(x);
    x = '{default: 32'hffffffff};
    send(x);
    send(mk(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 32'h7fffffff, 32'h80000000));
    send(mk(32'h100, 32'h100, 32'h100, 32'h10000, 1, 0, 32'h10000, 2, 0));

    for (int ph = 0; ph < 5; ph++) begin
      in_valid <= 1'b0;
      settle();
      write_reg(spns_pkg::CFG_LENGTH_TOL, lt[ph]);
      write_reg(spns_pkg::CFG_DET_TOL, dt[ph]);
      for (int i = 0; i < 140; i++) begin
        if (i % 35 == 0) max_gap = $urandom_range(0, 1) ? 4 : 0;
        send(rand_query());
      end
    end
    in_valid <= 1'b0;
    max_gap = 4;
    settle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
